### rtl/distinct_index_sampler_macros.svh
// Assertion helpers for the checker in dis_checker.sv
`ifndef DISTINCT_INDEX_SAMPLER_MACROS_SVH
`define DISTINCT_INDEX_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DIS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("distinct_index_sampler check failed");

// Next-cycle implication, sampled on clk, off during reset
`define DIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("distinct_index_sampler check failed");

`endif

### rtl/dis_pkg.sv
package dis_pkg;

	localparam int SLOT_COUNT     = 136;
	localparam int WANTED_INDICES = 134;
	localparam int SLOT_AW        = $clog2(SLOT_COUNT);
	localparam int CNT_W          = $clog2(SLOT_COUNT + 1);
	localparam int WORD_W         = 32;
	localparam int LIMIT_W        = 31;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd24646;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_OFFER = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Control from the sequencer to the shared compare unit
	typedef struct packed {
		logic clr;
		logic en;
		logic vld;
	} match_ctl_t;

endpackage

### rtl/dis_ram.sv
module dis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 136
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/dis_match.sv
module dis_match (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dis_pkg::match_ctl_t             ctl,
	input  logic [dis_pkg::WORD_W-1:0]      rd_data,
	input  logic [dis_pkg::WORD_W-1:0]      key,
	output logic                            dup
);

	logic [dis_pkg::WORD_W-1:0] slot_word;
	logic                       dup_q;

	// A slot never written since the last clear holds all ones
	assign slot_word = ctl.vld ? rd_data : {dis_pkg::WORD_W{1'b1}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q <= 1'b0;
		end else if (ctl.clr) begin
			dup_q <= 1'b0;
		end else if (ctl.en && (slot_word == key)) begin
			dup_q <= 1'b1;
		end
	end

	assign dup = dup_q;

endmodule

### rtl/distinct_index_sampler.sv
// distinct_index_sampler: collects distinct indices below index_limit into a
// 136-slot table. Pulse start while busy is low; the item is taken on that
// edge. Clear and unused kinds answer on the next cycle. A read goes through
// rd_item_s1, holding busy high, then done_q. An offer steps through ST_SCAN,
// where a single compare unit walks every slot through the one read port of the
// slot memory, then ST_LAST and ST_COMMIT, which commits the write. Each result
// shows for exactly one cycle with done high and cannot be stalled. The user
// must write index_limit with index_limit_we while idle; this is not enforced.
module distinct_index_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] random_word,
	input  logic [7:0]  slot_number,
	input  logic        index_limit_we,
	input  logic [30:0] index_limit,
	output logic        done,
	output logic [31:0] slot_value,
	output logic [7:0]  index_count,
	output logic        accepted
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_LAST   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [dis_pkg::LIMIT_W-1:0]       limit_q;
	logic [dis_pkg::LIMIT_W-1:0]       mask;
	logic [dis_pkg::WORD_W-1:0]        key_q;
	logic [dis_pkg::CNT_W-1:0]         ptr_q;
	logic [dis_pkg::CNT_W-1:0]         total_q;
	logic [dis_pkg::SLOT_COUNT-1:0]    valid_q;
	logic                              vld_s1;
	logic                              cmp_s1;
	logic                              rd_item_s1;
	logic                              rd_range_s1;
	logic                              done_q;
	logic [dis_pkg::WORD_W-1:0]        value_q;
	logic [7:0]                        count_q;
	logic                              acc_q;

	logic                              take;
	logic                              ram_we;
	logic [dis_pkg::SLOT_AW-1:0]       ram_waddr;
	logic                              ram_re;
	logic [dis_pkg::SLOT_AW-1:0]       ram_raddr;
	logic [dis_pkg::WORD_W-1:0]        ram_rdata;
	logic                              room;
	logic                              below;
	logic                              dup;
	dis_pkg::match_ctl_t               mctl;

	assign take = start && !busy;
	// Hold off new items during an offer and while a read result is still on its way
	assign busy = (state_q != ST_IDLE) || rd_item_s1;

	// Smear the limit downward: ones up to its highest set bit
	always_comb begin
		mask = limit_q;
		for (int s = 1; s < dis_pkg::LIMIT_W; s = s * 2) begin
			mask = mask | (mask >> s);
		end
	end

	assign room  = (total_q < dis_pkg::CNT_W'(dis_pkg::SLOT_COUNT));
	assign below = (key_q < {1'b0, limit_q});

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[dis_pkg::SLOT_AW-1:0];
		if (state_q == ST_SCAN) begin
			ram_re = 1'b1;
		end else if (take && (kind == dis_pkg::KIND_READ)) begin
			ram_re    = 1'b1;
			ram_raddr = slot_number[dis_pkg::SLOT_AW-1:0];
		end
	end

	assign ram_we    = (state_q == ST_COMMIT) && room;
	assign ram_waddr = total_q[dis_pkg::SLOT_AW-1:0];

	assign mctl.clr = take;
	assign mctl.en  = cmp_s1;
	assign mctl.vld = vld_s1;

	dis_ram #(
		.WIDTH(dis_pkg::WORD_W),
		.DEPTH(dis_pkg::SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(key_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dis_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.rd_data(ram_rdata),
		.key    (key_q),
		.dup    (dup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= dis_pkg::LIMIT_RESET;
			ptr_q       <= '0;
			total_q     <= '0;
			valid_q     <= '0;
			cmp_s1      <= 1'b0;
			rd_item_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			cmp_s1     <= 1'b0;
			rd_item_s1 <= 1'b0;
			if (index_limit_we) begin
				limit_q <= index_limit;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (kind)
							dis_pkg::KIND_CLEAR: begin
								valid_q <= '0;
								total_q <= '0;
								done_q  <= 1'b1;
							end
							dis_pkg::KIND_OFFER: begin
								ptr_q   <= '0;
								state_q <= ST_SCAN;
							end
							dis_pkg::KIND_READ: begin
								rd_item_s1 <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
					if (rd_item_s1) begin
						done_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					cmp_s1 <= 1'b1;
					ptr_q  <= ptr_q + 1'b1;
					if (ptr_q == dis_pkg::CNT_W'(dis_pkg::SLOT_COUNT - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// last compare lands this cycle
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (room) begin
						valid_q[total_q[dis_pkg::SLOT_AW-1:0]] <= 1'b1;
						if (below && !dup) begin
							total_q <= total_q + 1'b1;
						end
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload side: no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			key_q       <= random_word & {1'b0, mask};
			rd_range_s1 <= (slot_number < 8'(dis_pkg::SLOT_COUNT));
		end
		if (ram_re) begin
			vld_s1 <= valid_q[ram_raddr];
		end
		if (take && (kind != dis_pkg::KIND_READ) && (kind != dis_pkg::KIND_OFFER)) begin
			value_q <= '0;
			acc_q   <= 1'b0;
			count_q <= (kind == dis_pkg::KIND_CLEAR) ? 8'd0 : 8'(total_q);
		end
		if (rd_item_s1) begin
			value_q <= !rd_range_s1 ? '0 :
				(vld_s1 ? ram_rdata : {dis_pkg::WORD_W{1'b1}});
			acc_q   <= 1'b0;
			count_q <= 8'(total_q);
		end
		if (state_q == ST_COMMIT) begin
			value_q <= '0;
			acc_q   <= room && below && !dup;
			count_q <= 8'(total_q) + 8'(room && below && !dup);
		end
	end

	assign done        = done_q;
	assign slot_value  = value_q;
	assign index_count = count_q;
	assign accepted    = acc_q;

endmodule

### rtl/dis_checker.sv
`include "distinct_index_sampler_macros.svh"

module dis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        done,
	input logic [31:0] slot_value,
	input logic [7:0]  index_count,
	input logic        accepted
);

	`DIS_ASSERT_NOW(a_done_idle, done, !busy)
	`DIS_ASSERT_NOW(a_acc_no_value, done && accepted, slot_value == 32'd0)
	`DIS_ASSERT_NOW(a_count_bound, done, index_count <= 8'(dis_pkg::SLOT_COUNT))
	`DIS_ASSERT_NOW(a_acc_count_nonzero, done && accepted, index_count != 8'd0)
	`DIS_ASSERT_NEXT(a_offer_busy, start && !busy && (kind == dis_pkg::KIND_OFFER), busy)

endmodule

bind distinct_index_sampler dis_checker u_dis_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.kind       (kind),
	.done       (done),
	.slot_value (slot_value),
	.index_count(index_count),
	.accepted   (accepted)
);

### verif/sampler_checker.sv
module sampler_checker
	import dis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] random_word,
	input  logic [7:0]  slot_number,
	input  logic        index_limit_we,
	input  logic [30:0] index_limit,
	input  logic        done,
	input  logic [31:0] slot_value,
	input  logic [7:0]  index_count,
	input  logic        accepted,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  count;
		logic        acc;
	} slot_result_t;

	logic [31:0]        slot_copy [SLOT_COUNT];
	int unsigned        filled;
	logic [LIMIT_W-1:0] limit_copy;
	slot_result_t       awaited_results [$];

	function automatic void empty_table();
		foreach (slot_copy[i])
			slot_copy[i] = '1;
		filled = 0;
	endfunction

	// Apply one item to the table copy and return the result it yields
	function automatic slot_result_t sample_slot_item(kind_t k, logic [31:0] w, logic [7:0] s);
		slot_result_t r;
		logic [31:0]  msk;
		logic [31:0]  idx;
		bit           dup;
		r = '0;
		case (k)
			KIND_CLEAR: begin
				empty_table();
			end
			KIND_OFFER: begin
				msk = 32'((64'd1 << $clog2(64'(limit_copy) + 1)) - 1);
				idx = w & msk;
				dup = 1'b0;
				// compare against the table as it was, stale words included
				foreach (slot_copy[i])
					if (slot_copy[i] == idx)
						dup = 1'b1;
				if (filled < SLOT_COUNT) begin
					slot_copy[filled] = idx;
					if (idx < limit_copy && !dup) begin
						filled++;
						r.acc = 1'b1;
					end
				end
			end
			KIND_READ: begin
				if (s < SLOT_COUNT)
					r.value = slot_copy[s];
			end
			default: ;
		endcase
		r.count = filled[7:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		if (!arst_n) begin
			empty_table();
			limit_copy = LIMIT_RESET;
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none awaited: value %h count %0d acc %0d",
						$time, slot_value, index_count, accepted);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (slot_value !== want.value) begin
						$display("%0t: slot_value expected %h, got %h",
							$time, want.value, slot_value);
						fail_count++;
					end
					if (index_count !== want.count) begin
						$display("%0t: index_count expected %0d, got %0d",
							$time, want.count, index_count);
						fail_count++;
					end
					if (accepted !== want.acc) begin
						$display("%0t: accepted expected %0d, got %0d",
							$time, want.acc, accepted);
						fail_count++;
					end
				end
			end
			if (index_limit_we)
				limit_copy = index_limit;
			if (start && !busy)
				awaited_results.push_back(sample_slot_item(kind_t'(kind), random_word,
					slot_number));
		end
		outstanding = awaited_results.size();
	end

endmodule

### verif/testbench.sv
module testbench;
	import dis_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [31:0] random_word;
	logic [7:0]  slot_number;
	logic        index_limit_we;
	logic [30:0] index_limit;
	logic        done;
	logic [31:0] slot_value;
	logic [7:0]  index_count;
	logic        accepted;
	int          fail_count;
	int          outstanding;

	logic        item_taken;
	int          idle_pct;
	int unsigned cur_limit;
	logic [31:0] recent_words [8];
	int          recent_ptr;
	int unsigned cycle_count = 0;

	distinct_index_sampler dut (.*);

	sampler_checker result_watch (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		item_taken <= arst_n && start && !busy;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer words: fully random ones, recent repeats, limit edges and small valid pools
	// for duplicates; the edges and pools get random bits above the mask
	function automatic logic [31:0] pick_word();
		int          r;
		int unsigned shift;
		logic [31:0] v;
		shift = $clog2(64'(cur_limit) + 1);
		r = $urandom_range(0, 99);
		if (r < 20)
			return $urandom();
		if (r < 40)
			return recent_words[$urandom_range(0, 7)];
		if (r < 55) begin
			case ($urandom_range(0, 2))
				0: v = (cur_limit == 0) ? 32'd0 : 32'(cur_limit - 1);
				1: v = 32'(cur_limit);
				default: v = 32'((64'd1 << shift) - 1);
			endcase
		end else begin
			v = $urandom_range(0, (cur_limit == 0) ? 0 :
				((cur_limit - 1 < 160) ? cur_limit - 1 : 160));
		end
		return v | ($urandom() << shift);
	endfunction

	task automatic send_item(kind_t k, logic [31:0] w, logic [7:0] s);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			kind <= 2'($urandom());
			random_word <= $urandom();
			slot_number <= 8'($urandom());
			@(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		random_word <= w;
		slot_number <= s;
		if (k == KIND_OFFER) begin
			recent_words[recent_ptr] = w;
			recent_ptr = (recent_ptr + 1) % 8;
		end
		do @(negedge clk); while (!item_taken);
	endtask

	// Drain the block, then write the limit
	task automatic write_limit(int unsigned v);
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
		repeat (2) @(negedge clk);
		index_limit_we <= 1'b1;
		index_limit <= 31'(v);
		cur_limit = v;
		@(negedge clk);
		index_limit_we <= 1'b0;
	endtask

	task automatic run_random(int n);
		int    r;
		kind_t k;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				k = KIND_OFFER;
			else if (r < 88)
				k = KIND_READ;
			else if (r < 94)
				k = KIND_CLEAR;
			else
				k = KIND_NONE;
			send_item(k, pick_word(), ($urandom_range(0, 99) < 80) ?
				8'($urandom_range(0, SLOT_COUNT - 1)) : 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int unsigned phase_limits [5];
		start = 1'b0;
		kind = KIND_CLEAR;
		random_word = '0;
		slot_number = '0;
		index_limit_we = 1'b0;
		index_limit = '0;
		arst_n = 1'b0;
		idle_pct = 30;
		cur_limit = 32'(LIMIT_RESET);
		recent_ptr = 0;
		foreach (recent_words[i])
			recent_words[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset table, read edges and the unused kind
		send_item(KIND_READ, $urandom(), 8'd0);
		send_item(KIND_READ, $urandom(), 8'd135);
		send_item(KIND_READ, $urandom(), 8'd136);
		send_item(KIND_READ, $urandom(), 8'd255);
		send_item(KIND_NONE, $urandom(), 8'($urandom()));
		// offers at the reset limit: duplicate after masking, limit edges
		send_item(KIND_OFFER, 32'd0, 8'd0);
		send_item(KIND_OFFER, 32'h8000_0000, 8'd0);
		send_item(KIND_OFFER, 32'd24645, 8'd0);
		send_item(KIND_OFFER, 32'd24646, 8'd0);
		send_item(KIND_OFFER, 32'hffff_ffff, 8'd0);
		send_item(KIND_OFFER, 32'd32767, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd2);
		send_item(KIND_OFFER, 32'h7fff_ffff, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd1);
		send_item(KIND_CLEAR, $urandom(), 8'($urandom()));
		send_item(KIND_READ, 32'd0, 8'd0);
		send_item(KIND_OFFER, 32'hdead_0005, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd0);
		send_item(KIND_NONE, 32'hffff_ffff, 8'hff);

		// tiny limits
		write_limit(1);
		send_item(KIND_CLEAR, 32'd0, 8'd0);
		send_item(KIND_OFFER, 32'hffff_fffe, 8'd0);
		send_item(KIND_OFFER, 32'd1, 8'd0);
		send_item(KIND_OFFER, 32'd0, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd1);
		write_limit(0);
		send_item(KIND_OFFER, $urandom(), 8'd0);
		send_item(KIND_OFFER, 32'd0, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd2);
		write_limit(2);
		send_item(KIND_OFFER, 32'd1, 8'd0);
		send_item(KIND_OFFER, 32'd3, 8'd0);
		send_item(KIND_OFFER, 32'd2, 8'd0);
		send_item(KIND_READ, 32'd0, 8'd0);

		// fill the table past its end with ascending indices
		write_limit(256);
		send_item(KIND_CLEAR, $urandom(), 8'($urandom()));
		idle_pct = 0;
		for (int k = 0; k < 150; k++) begin
			if (k == 80)
				idle_pct = 30;
			if ($urandom_range(0, 99) < 10)
				send_item(KIND_OFFER, 32'($urandom_range(256, 511)) | ($urandom() << 9),
					8'd0);
			else if ($urandom_range(0, 99) < 8)
				send_item(KIND_OFFER, 32'($urandom_range(0, k)) | ($urandom() << 9), 8'd0);
			send_item(KIND_OFFER, 32'(k) | ($urandom() << 9), 8'($urandom()));
		end
		send_item(KIND_READ, 32'd0, 8'd135);
		send_item(KIND_READ, 32'd0, 8'd136);
		repeat (12)
			send_item(KIND_READ, $urandom(), 8'($urandom_range(0, 255)));

		phase_limits[0] = 32'h7fff_ffff;
		phase_limits[1] = 2;
		phase_limits[2] = $urandom_range(3, 300);
		phase_limits[3] = $urandom_range(137, 4000);
		phase_limits[4] = $urandom_range(4001, 32'h7fff_fffe);
		foreach (phase_limits[i]) begin
			write_limit(phase_limits[i]);
			run_random(45);
		end

		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (150) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### distinct_index_sampler.f
+incdir+rtl
rtl/dis_pkg.sv
rtl/dis_ram.sv
rtl/dis_match.sv
rtl/distinct_index_sampler.sv
rtl/dis_checker.sv
verif/sampler_checker.sv
verif/testbench.sv
